/* sv/slfe_pkg.sv */
// Shared types and constants of the sync and length field frame extractor.
`timescale 1ns / 1ps

package slfe_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd70;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_VALUE  = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1
  } cfg_index_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_DATA   = 1'b1
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e        kind;
    logic               last;
    logic [POS_W-1:0]   pos;
  } entry_info_t;

endpackage

/* sv/sync_length_frame_extractor_unit.sv */
// Top level of the sync byte and length field frame extractor.
// A payload byte passes through the queue and then the output register on its way to the output.
// A header run appears HEADER_BYTES results long, one per cycle while the output is not stalled.
// Throughput: one input byte per cycle while the queue is not full; the back end emits a
// header run byte by byte while a QUEUE_DEPTH entry queue takes the bytes that follow.
// Reset: hunting for sync, sync value 0xAA, maximum payload 70, queue and output empty.
`timescale 1ns / 1ps

module sync_length_frame_extractor_unit #(
  parameter int unsigned HEADER_BYTES = slfe_pkg::HEADER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = slfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [slfe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [slfe_pkg::BYTE_W-1:0]    cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [7:0]                     s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] frame_byte, [16:8] byte_position, [23:17] zero
  output logic [23:0]                    m_axis_tdata_o,
  output logic                           m_axis_tlast_o
);
  import slfe_pkg::*;

  logic                                 accept, push, full, pop, head_valid;
  entry_info_t                          push_info, head_info;
  logic [HEADER_BYTES-1:0][BYTE_W-1:0]  push_bytes, head_bytes;
  logic [BYTE_W-1:0]                    out_byte;
  logic [POS_W-1:0]                     out_pos;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  slfe_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .rx_byte_i    (s_axis_tdata_i),
    .push_o       (push),
    .push_info_o  (push_info),
    .push_bytes_o (push_bytes)
  );

  slfe_queue #(.HEADER_BYTES(HEADER_BYTES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_info_i  (push_info),
    .push_bytes_i (push_bytes),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_info_o  (head_info),
    .head_bytes_o (head_bytes)
  );

  slfe_back #(.HEADER_BYTES(HEADER_BYTES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_info_i  (head_info),
    .head_bytes_i (head_bytes),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (out_byte),
    .out_pos_o    (out_pos),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, out_pos, out_byte};

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> !push)
    else $error("entry pushed into a full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("pop from an empty queue");

  // A frame never ends inside its header run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (out_pos >= POS_W'(HEADER_BYTES - 1)))
    else $error("frame end before the header is complete");

endmodule

/* sv/slfe_front.sv */
// Front end: configuration registers, sync hunt, header gathering and payload classification.
`timescale 1ns / 1ps

module slfe_front #(
  parameter int unsigned HEADER_BYTES = slfe_pkg::HEADER_BYTES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  input  logic [slfe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [slfe_pkg::BYTE_W-1:0]            cfg_data_i,
  input  logic                                   accept_i,
  input  logic [slfe_pkg::BYTE_W-1:0]            rx_byte_i,
  output logic                                   push_o,
  output slfe_pkg::entry_info_t                  push_info_o,
  output logic [HEADER_BYTES-1:0][slfe_pkg::BYTE_W-1:0] push_bytes_o
);
  import slfe_pkg::*;

  localparam int unsigned CW = $clog2(HEADER_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [CW-1:0]           hcnt_q, hcnt_d;
  logic [BYTE_W-1:0]       rem_q, rem_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [BYTE_W-1:0]       sync_q, max_q;
  logic [HEADER_BYTES-2:0][BYTE_W-1:0] store_q;
  logic [BYTE_W-1:0]       rem_dec;
  logic                    data_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_VALUE_RESET;
      max_q  <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SYNC_VALUE) begin
        sync_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_MAX_PAYLOAD) begin
        max_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && phase_q == PH_HEAD) begin
      for (int k = 0; k < HEADER_BYTES - 1; k++) begin
        if (hcnt_q == CW'(k)) begin
          store_q[k] <= rx_byte_i;
        end
      end
    end
  end

  assign rem_dec   = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign data_last = (rem_dec == '0);

  always_comb begin
    phase_d      = phase_q;
    hcnt_d       = hcnt_q;
    rem_d        = rem_q;
    pos_d        = pos_q;
    push_o       = 1'b0;
    push_info_o  = '{kind: KIND_DATA, last: 1'b0, pos: '0};
    push_bytes_o = '0;
    push_bytes_o[0] = rx_byte_i;
    if (accept_i) begin
      case (phase_q)
        PH_HEAD: begin
          if (hcnt_q == CW'(HEADER_BYTES - 2)) begin
            hcnt_d = '0;
            if (rx_byte_i > max_q) begin
              phase_d = PH_HUNT;
            end else begin
              push_o           = 1'b1;
              push_info_o.kind = KIND_HEADER;
              push_info_o.last = (rx_byte_i == '0);
              push_bytes_o[0]  = sync_q;
              for (int k = 1; k < HEADER_BYTES - 1; k++) begin
                push_bytes_o[k] = store_q[k-1];
              end
              push_bytes_o[HEADER_BYTES-1] = rx_byte_i;
              phase_d = (rx_byte_i == '0) ? PH_HUNT : PH_DATA;
              rem_d   = rx_byte_i;
              pos_d   = POS_W'(HEADER_BYTES);
            end
          end else begin
            hcnt_d = hcnt_q + 1'b1;
          end
        end
        PH_DATA: begin
          push_o           = 1'b1;
          push_info_o.kind = KIND_DATA;
          push_info_o.last = data_last;
          push_info_o.pos  = pos_q;
          rem_d            = rem_dec;
          if (data_last) begin
            phase_d = PH_HUNT;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == sync_q) begin
            phase_d = PH_HEAD;
            hcnt_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      hcnt_q  <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* sv/slfe_queue.sv */
// Short queue of classified entries between the front end and the back end.
`timescale 1ns / 1ps

module slfe_queue #(
  parameter int unsigned HEADER_BYTES = slfe_pkg::HEADER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = slfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  input  slfe_pkg::entry_info_t                  push_info_i,
  input  logic [HEADER_BYTES-1:0][slfe_pkg::BYTE_W-1:0] push_bytes_i,
  output logic                                   full_o,
  input  logic                                   pop_i,
  output logic                                   head_valid_o,
  output slfe_pkg::entry_info_t                  head_info_o,
  output logic [HEADER_BYTES-1:0][slfe_pkg::BYTE_W-1:0] head_bytes_o
);
  import slfe_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  entry_info_t                              info_q  [QUEUE_DEPTH];
  logic [HEADER_BYTES-1:0][BYTE_W-1:0]      bytes_q [QUEUE_DEPTH];
  logic [AW:0]                              wr_ptr_q, rd_ptr_q;

  assign head_valid_o = (wr_ptr_q != rd_ptr_q);
  assign full_o       = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
                        (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign head_info_o  = info_q[rd_ptr_q[AW-1:0]];
  assign head_bytes_o = bytes_q[rd_ptr_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      info_q[wr_ptr_q[AW-1:0]]  <= push_info_i;
      bytes_q[wr_ptr_q[AW-1:0]] <= push_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

/* sv/slfe_back.sv */
// Back end: expands queue entries into frame bytes and holds them in the output register.
`timescale 1ns / 1ps

module slfe_back #(
  parameter int unsigned HEADER_BYTES = slfe_pkg::HEADER_BYTES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   head_valid_i,
  input  slfe_pkg::entry_info_t                  head_info_i,
  input  logic [HEADER_BYTES-1:0][slfe_pkg::BYTE_W-1:0] head_bytes_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [slfe_pkg::BYTE_W-1:0]            out_byte_o,
  output logic [slfe_pkg::POS_W-1:0]             out_pos_o,
  output logic                                   out_last_o
);
  import slfe_pkg::*;

  localparam int unsigned IW = $clog2(HEADER_BYTES);

  logic [IW-1:0]     idx_q, idx_d;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_last_q;
  logic              load, take, is_end, is_header;

  assign load      = !out_valid_q || out_ready_i;
  assign take      = head_valid_i && load;
  assign is_header = (head_info_i.kind == KIND_HEADER);
  assign is_end    = !is_header || (idx_q == IW'(HEADER_BYTES - 1));
  assign pop_o     = take && is_end;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = is_end ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= head_bytes_i[idx_q];
      out_pos_q  <= is_header ? POS_W'(idx_q) : head_info_i.pos;
      out_last_q <= is_end && head_info_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_pos_o   = out_pos_q;
  assign out_last_o  = out_last_q;

endmodule

/* sim/tb.sv */
// Self-checking testbench of the sync and length field frame extractor.
`timescale 1ns / 1ps

module tb;
  import slfe_pkg::*;

  localparam int HDR = HEADER_BYTES_DEF;
  localparam int DRAIN_CYCLES = HEADER_BYTES_DEF + QUEUE_DEPTH_DEF + 4;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LONG_FRAME_LEN = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_HEADER  = 2'd1,
    ST_PAYLOAD = 2'd2
  } deframe_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_beat_t;

  class frame_scoreboard;
    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] max_reg;
    deframe_state_e    state;
    logic [BYTE_W-1:0] hdr_bytes[HDR-1];
    int                hdr_cnt;
    logic [BYTE_W-1:0] pay_left;
    logic [POS_W-1:0]  pos_next;
    frame_beat_t       beats[$];
    int                errors;

    function new();
      sync_reg = SYNC_VALUE_RESET;
      max_reg  = MAX_PAYLOAD_RESET;
      state    = ST_HUNT;
      hdr_cnt  = 0;
      pay_left = '0;
      pos_next = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      if (idx == CFG_SYNC_VALUE) begin
        sync_reg = val;
      end else if (idx == CFG_MAX_PAYLOAD) begin
        max_reg = val;
      end
    endfunction

    function void push_beat(logic [BYTE_W-1:0] b, logic [POS_W-1:0] p, logic l);
      frame_beat_t beat;
      beat.fbyte = b;
      beat.pos   = p;
      beat.last  = l;
      beats.push_back(beat);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      logic lst;
      case (state)
        ST_HEADER: begin
          if (hdr_cnt < HDR - 1) hdr_bytes[hdr_cnt] = b;
          hdr_cnt++;
          if (hdr_cnt >= HDR - 1) begin
            hdr_cnt = 0;
            if (b > max_reg) begin
              state = ST_HUNT;
            end else begin
              push_beat(sync_reg, '0, 1'b0);
              for (int k = 1; k < HDR; k++) begin
                push_beat(hdr_bytes[k-1], POS_W'(k), (k == HDR - 1) && (b == 0));
              end
              if (b == 0) begin
                state = ST_HUNT;
              end else begin
                state    = ST_PAYLOAD;
                pay_left = b;
                pos_next = POS_W'(HDR);
              end
            end
          end
        end
        ST_PAYLOAD: begin
          if (pay_left > 0) pay_left--;
          lst = (pay_left == 0);
          push_beat(b, pos_next, lst);
          pos_next++;
          if (lst) begin
            state    = ST_HUNT;
            pos_next = '0;
          end
        end
        default: begin
          state = ST_HUNT;
          if (b == sync_reg) begin
            state   = ST_HEADER;
            hdr_cnt = 0;
          end
        end
      endcase
    endfunction

    function void check_beat(logic [23:0] data, logic last);
      frame_beat_t want;
      if (beats.size() == 0) begin
        $display("%0t: unexpected output transaction: expected none, actual data %h last %b",
                 $time, data, last);
        errors++;
      end else begin
        want = beats.pop_front();
        if (data[7:0] !== want.fbyte) begin
          $display("%0t: frame_byte expected %h actual %h", $time, want.fbyte, data[7:0]);
          errors++;
        end
        if (data[16:8] !== want.pos) begin
          $display("%0t: byte_position expected %0d actual %0d", $time, want.pos, data[16:8]);
          errors++;
        end
        if (last !== want.last) begin
          $display("%0t: frame_last expected %b actual %b", $time, want.last, last);
          errors++;
        end
      end
    endfunction

    function int pending();
      return beats.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [7:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [23:0] m_data;
  logic m_last;

  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic long_hold = 1'b0;
  int stall_cnt = 0;

  frame_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  sync_length_frame_extractor_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_beat(m_data, m_last);
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt + 1 >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_ready <= 1'b0;
      end else if (long_hold) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(negedge clk_i);
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    sb.note_byte(b);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_valid <= 1'b0;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_frame(input int len, input logic [7:0] h1, input logic [7:0] h2);
    logic [7:0] pb;
    send_byte(sb.sync_reg);
    send_byte(h1);
    send_byte(h2);
    send_byte(8'(len));
    if (len <= sb.max_reg) begin
      for (int i = 0; i < len; i++) begin
        pb = ($urandom_range(0, 7) == 0) ? sb.sync_reg : 8'($urandom);
        send_byte(pb);
      end
    end
  endtask

  initial begin
    int sent;
    int len;
    int m;
    int r;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [7:0] sv;
    logic [7:0] mv;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_frame(2, 8'h12, 8'h34);
    send_frame(0, 8'h55, 8'hAA);
    send_frame(71, 8'h01, 8'h02);
    send_frame(1, 8'h03, 8'h04);

    // The sync register is rewritten while a header is half gathered.
    send_byte(8'hAA);
    send_byte(8'h01);
    stop_sending();
    drain();
    cfg_write(CFG_SYNC_VALUE, 8'h3C);
    send_byte(8'h80);
    send_byte(8'h00);
    stop_sending();
    drain();

    cfg_write(CFG_SYNC_VALUE, 8'h00);
    cfg_write(CFG_MAX_PAYLOAD, 8'h00);
    cfg_write(CFG_SPARE_A, 8'hFF);
    cfg_write(CFG_SPARE_B, 8'h00);
    send_frame(0, 8'hFF, 8'hFF);
    send_frame(1, 8'hFF, 8'hFF);
    stop_sending();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sv = SYNC_VALUE_RESET; mv = MAX_PAYLOAD_RESET; end
        1: begin sv = 8'h00; mv = 8'h00; end
        2: begin sv = 8'hFF; mv = 8'hFF; end
        3: begin sv = 8'($urandom); mv = 8'd12; end
        4: begin sv = 8'($urandom); mv = 8'($urandom); end
        default: begin sv = SYNC_VALUE_RESET; mv = 8'd5; end
      endcase
      drain();
      cfg_write(CFG_SYNC_VALUE, sv);
      cfg_write(CFG_MAX_PAYLOAD, mv);
      tx_idle_on = (ph < 3) || (ph == 4);
      rx_idle_on = (ph < 5);
      if (ph == 2) begin
        @(posedge clk_i);
        long_hold = 1'b1;
        send_frame(LONG_FRAME_LEN, 8'($urandom), 8'($urandom));
      end
      sent = 0;
      m = sb.max_reg;
      while (sent < 20) begin
        if ($urandom_range(0, 3) != 0) begin
          h1 = ($urandom_range(0, 5) == 0) ? sb.sync_reg : 8'($urandom);
          h2 = ($urandom_range(0, 5) == 0) ? sb.sync_reg : 8'($urandom);
          r = $urandom_range(0, 5);
          case (r)
            0: len = 0;
            1: len = (m <= 20) ? m : $urandom_range(0, 20);
            2: len = (m < 255) ? m + 1 : m;
            3: len = (m < 255) ? $urandom_range(m + 1, 255) : $urandom_range(0, 20);
            default: len = $urandom_range(0, (m < 10) ? m : 10);
          endcase
          send_frame(len, h1, h2);
          sent += (len <= m) ? HDR + len : HDR;
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end
      end
      stop_sending();
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
